>>> rtl/mersenne_twister_prng_macros.svh
// assertion macros used by the mersenne twister back end (mtp_back)
// expects clk and rst_n in the scope of the including module
`ifndef MERSENNE_TWISTER_PRNG_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MTP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mtp_pkg.sv
// shared types and constants of the mersenne twister generator
// no dependencies
package mtp_pkg;

  localparam int WORD_W = 32;

  // operation field codes
  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_SEED     = 1'b1;

  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC60000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] seed_value;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic              auto_seeded;
  } out_res_t;

  typedef enum logic {
    CMD_GEN,
    CMD_SEED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [WORD_W-1:0] seed;
  } cmd_t;

endpackage

>>> rtl/mtp_ram.sv
// generic simple dual-read ram, one write port, two registered read ports
// no dependencies
module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] addr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] addr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem_r[addr_a];
    end
    if (re_b) begin
      rdata_b <= mem_r[addr_b];
    end
  end

endmodule

>>> rtl/mtp_front.sv
// front end: accepts requests, classifies them and queues them
// depends on mtp_pkg
module mtp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mtp_pkg::in_req_t in_req,
  output logic             q_valid,
  output mtp_pkg::cmd_t    q_cmd,
  input  logic             q_pop
);
  import mtp_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    cmd_in.kind = (in_req.operation == OP_SEED) ? CMD_SEED : CMD_GEN;
    cmd_in.seed = in_req.seed_value;
    wr_ptr_nxt  = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt  = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt     = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> rtl/mtp_back.sv
// back end: seeding, twisting and tempering over the state table ram
// depends on mtp_pkg, mtp_ram and the assertion macros
`include "mersenne_twister_prng_macros.svh"

module mtp_back #(
  parameter int STATE_WORDS  = 624,
  parameter int TWIST_OFFSET = 397
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mtp_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mtp_pkg::out_res_t out_res
);
  import mtp_pkg::*;

  localparam int AW = $clog2(STATE_WORDS);
  localparam int PW = $clog2(STATE_WORDS + 2);
  localparam logic [PW-1:0] POS_END  = PW'(STATE_WORDS);
  localparam logic [PW-1:0] POS_NEW  = PW'(STATE_WORDS + 1);
  localparam logic [PW-1:0] IDX_LAST = PW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] ADR_LAST = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] FAR0     = AW'(TWIST_OFFSET % STATE_WORDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_TWIST
  } state_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  state_t            state_r, state_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     ki_r, ki_nxt;
  logic [AW-1:0]     kw_r, kw_nxt;
  logic [AW-1:0]     far_r, far_nxt;
  logic              tw_v_r, tw_v_nxt;
  logic              cur_r, cur_nxt;
  logic [WORD_W-1:0] head_r, head_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic              auto_pend_r, auto_pend_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic              rd_auto_r, rd_auto_nxt;
  logic              out_v_r, out_v_nxt;
  out_res_t          out_res_r, out_res_nxt;
  logic              fwd_a_r, fwd_a_nxt;
  logic              fwd_b_r, fwd_b_nxt;
  logic [WORD_W-1:0] fwd_d_r, fwd_d_nxt;

  logic              we, re_a, re_b;
  logic [AW-1:0]     waddr, addr_a, addr_b;
  logic [WORD_W-1:0] wdata, rdata_a, rdata_b;
  logic [WORD_W-1:0] a_word, b_word;
  logic [WORD_W-1:0] seed_mix, seed_prod;
  logic [WORD_W-1:0] tw_mix, tw_shift;
  logic [PW-1:0]     ki_inc;
  logic              rd_moves, can_issue;

  mtp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .addr_a  (addr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .addr_b  (addr_b),
    .rdata_b (rdata_b)
  );

  assign q_pop     = (state_r == ST_IDLE) && q_valid && (
                       (q_cmd.kind == CMD_SEED) ||
                       ((pos_r != POS_NEW) && (pos_r != POS_END) && can_issue));
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  // words written in the same cycle as their read are bypassed
  assign a_word    = fwd_a_r ? fwd_d_r : rdata_a;
  assign b_word    = fwd_b_r ? fwd_d_r : rdata_b;
  assign rd_moves  = rd_v_r && (!out_v_r || !out_stall);
  assign can_issue = !rd_v_r || rd_moves;
  assign ki_inc    = ki_r + 1'b1;
  assign seed_mix  = x_r ^ (x_r >> 30);
  assign seed_prod = INIT_MULT * seed_mix;
  assign tw_mix    = {cur_r, a_word[WORD_W-2:0]};
  assign tw_shift  = (tw_mix >> 1) ^ (tw_mix[0] ? TWIST_MATRIX : '0);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    ki_nxt        = ki_r;
    kw_nxt        = kw_r;
    far_nxt       = far_r;
    tw_v_nxt      = tw_v_r;
    cur_nxt       = cur_r;
    head_nxt      = head_r;
    x_nxt         = x_r;
    auto_pend_nxt = auto_pend_r;
    rd_v_nxt      = rd_v_r;
    rd_auto_nxt   = rd_auto_r;
    out_v_nxt     = out_v_r;
    out_res_nxt   = out_res_r;
    fwd_a_nxt     = fwd_a_r;
    fwd_b_nxt     = fwd_b_r;
    fwd_d_nxt     = fwd_d_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re_a          = 1'b0;
    addr_a        = '0;
    re_b          = 1'b0;
    addr_b        = '0;

    // tempering stage into the output register
    if (rd_moves) begin
      out_v_nxt               = 1'b1;
      out_res_nxt.random_word = temper(a_word);
      out_res_nxt.auto_seeded = rd_auto_r;
      rd_v_nxt                = 1'b0;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == CMD_SEED) begin
            x_nxt     = q_cmd.seed;
            ki_nxt    = '0;
            state_nxt = ST_SEED;
          end else if (pos_r == POS_NEW) begin
            x_nxt         = DEFAULT_SEED;
            ki_nxt        = '0;
            auto_pend_nxt = 1'b1;
            state_nxt     = ST_SEED;
          end else if (pos_r == POS_END) begin
            if (!rd_v_r) begin
              ki_nxt    = '0;
              far_nxt   = FAR0;
              cur_nxt   = head_r[WORD_W-1];
              tw_v_nxt  = 1'b0;
              state_nxt = ST_TWIST;
            end
          end else if (can_issue) begin
            re_a          = 1'b1;
            addr_a        = pos_r[AW-1:0];
            pos_nxt       = pos_r + 1'b1;
            rd_v_nxt      = 1'b1;
            rd_auto_nxt   = auto_pend_r;
            auto_pend_nxt = 1'b0;
          end
        end
      end
      ST_SEED: begin
        we     = 1'b1;
        waddr  = ki_r[AW-1:0];
        wdata  = x_r;
        x_nxt  = seed_prod + WORD_W'(ki_inc);
        ki_nxt = ki_inc;
        if (ki_r == '0) begin
          head_nxt = x_r;
        end
        if (ki_r == IDX_LAST) begin
          pos_nxt   = POS_END;
          state_nxt = ST_IDLE;
        end
      end
      ST_TWIST: begin
        // write back the entry whose reads came in last cycle
        if (tw_v_r) begin
          we      = 1'b1;
          waddr   = kw_r;
          wdata   = b_word ^ tw_shift;
          cur_nxt = a_word[WORD_W-1];
          if (kw_r == '0) begin
            head_nxt = b_word ^ tw_shift;
          end
          if (kw_r == ADR_LAST) begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
        // issue reads of the next and far words for the following entry
        if (ki_r != POS_END) begin
          re_a     = 1'b1;
          re_b     = 1'b1;
          addr_a   = (ki_r == IDX_LAST) ? '0 : ki_r[AW-1:0] + 1'b1;
          addr_b   = far_r;
          far_nxt  = (far_r == ADR_LAST) ? '0 : far_r + 1'b1;
          kw_nxt   = ki_r[AW-1:0];
          ki_nxt   = ki_inc;
          tw_v_nxt = 1'b1;
        end else begin
          tw_v_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (re_a) begin
      fwd_a_nxt = we && (waddr == addr_a);
      fwd_d_nxt = wdata;
    end
    if (re_b) begin
      fwd_b_nxt = we && (waddr == addr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_NEW;
      tw_v_r      <= 1'b0;
      auto_pend_r <= 1'b0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      fwd_a_r     <= 1'b0;
      fwd_b_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      tw_v_r      <= tw_v_nxt;
      auto_pend_r <= auto_pend_nxt;
      rd_v_r      <= rd_v_nxt;
      out_v_r     <= out_v_nxt;
      fwd_a_r     <= fwd_a_nxt;
      fwd_b_r     <= fwd_b_nxt;
    end
    ki_r      <= ki_nxt;
    kw_r      <= kw_nxt;
    far_r     <= far_nxt;
    cur_r     <= cur_nxt;
    head_r    <= head_nxt;
    x_r       <= x_nxt;
    rd_auto_r <= rd_auto_nxt;
    out_res_r <= out_res_nxt;
    fwd_d_r   <= fwd_d_nxt;
  end

  `MTP_ASSERT_SAME(a_pos_range, 1'b1, pos_r <= POS_NEW, "read position out of range")
  `MTP_ASSERT_SAME(a_twist_no_read, state_r == ST_TWIST, !rd_v_r,
                   "word read pending during twist")
  `MTP_ASSERT_NEXT(a_seed_done, (state_r == ST_SEED) && (ki_r == IDX_LAST),
                   (pos_r == POS_END) && (state_r == ST_IDLE), "seed did not finish")
  `MTP_ASSERT_NEXT(a_twist_done, (state_r == ST_TWIST) && tw_v_r && (kw_r == ADR_LAST),
                   (pos_r == '0) && (state_r == ST_IDLE), "twist did not finish")
  `MTP_ASSERT_SAME(a_pop_idle, q_pop, (state_r == ST_IDLE) && q_valid,
                   "queue popped outside idle")

endmodule

>>> rtl/mersenne_twister_prng.sv
// top level of the 32-bit mersenne twister (mt19937) generator
// depends on mtp_pkg, mtp_front, mtp_back (which holds mtp_ram)

// MT19937 generator with a STATE_WORDS-entry state table held in a one-write,
// two-read RAM. A seed request fills the table with the standard
// initialization recurrence, one entry per cycle (one 32x32 multiply per
// entry), which holds the back end until the table is full, and gives no
// result. A generate request gives one tempered word; while unread words
// remain and out_stall does not hold the output, it issues one RAM read per
// cycle, so back-to-back generates yield one word per cycle, each read from
// the RAM, then tempered into the output register. Once every STATE_WORDS
// words the table is twisted in place, one entry per cycle through the single
// RAM write port, which delays that word, and more so while the previous word
// still sits in the read stage. A generate with no prior seed first seeds
// with 5489, then twists, and reports auto_seeded on its result.
// The table is not cleared after reset; it is always written by a seed before
// any read. Requests queue in a two-entry buffer, and the output register lets
// the generator keep working while a result waits under out_stall.
module mersenne_twister_prng #(
  parameter int STATE_WORDS  = 624,
  parameter int TWIST_OFFSET = 397
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  mtp_pkg::in_req_t  in_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output mtp_pkg::out_res_t out_res
);
  import mtp_pkg::*;

  // queue between the front and the back
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // front: classify requests into seed or generate commands
  mtp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // back: seed, twist and temper over the state table
  mtp_back #(
    .STATE_WORDS  (STATE_WORDS),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

>>> test/tb_mersenne_twister_prng.sv
// testbench for mersenne_twister_prng: queue-fed request driver, pattern-stalled result
// receiver and a checker that compares each result with an mt19937 predictor in this file
// depends on mtp_pkg and the rtl of mersenne_twister_prng
module tb_mersenne_twister_prng;
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam int STATE_WORDS   = 624;
  localparam int TWIST_OFFSET  = 397;
  // longest legal quiet spell is an auto seed plus a twist on top of the long
  // receiver hold-off, so this leaves a wide margin
  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 120;
  // random requests after the directed ones
  localparam int RANDOM_TARGET = 480;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  mersenne_twister_prng #(
    .STATE_WORDS (STATE_WORDS),
    .TWIST_OFFSET(TWIST_OFFSET)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  in_req_t  pending_reqs[$];   // requests not yet offered to the block
  out_res_t expected_words[$]; // predicted results, oldest first
  int       errors       = 0;
  int       results_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // generator predictor: own copy of the state table and read position
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] mt_table [STATE_WORDS];
  int unsigned       mt_pos = STATE_WORDS + 1; // past the end: never seeded

  // standard initialization recurrence, leaves the position at the end
  function automatic void mt_seed(logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    mt_table[0] = seed;
    for (int k = 1; k < STATE_WORDS; k++) begin
      prev = mt_table[k-1];
      mt_table[k] = INIT_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
    end
    mt_pos = STATE_WORDS;
  endfunction

  // in-place twist; later entries see the already twisted early ones
  function automatic void mt_twist();
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] shifted;
    for (int k = 0; k < STATE_WORDS; k++) begin
      mix = {mt_table[k][WORD_W-1], mt_table[(k + 1) % STATE_WORDS][WORD_W-2:0]};
      shifted = mix >> 1;
      if (mix[0]) shifted ^= TWIST_MATRIX;
      mt_table[k] = mt_table[(k + TWIST_OFFSET) % STATE_WORDS] ^ shifted;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [WORD_W-1:0] mt_temper(logic [WORD_W-1:0] y);
    y ^= y >> 11;
    y ^= (y << 7) & TEMPER_B;
    y ^= (y << 15) & TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  // apply one accepted request; a generate queues the word it must produce
  function automatic void advance_generator(in_req_t req);
    out_res_t res;
    if (req.operation == OP_SEED) begin
      mt_seed(req.seed_value);
    end else begin
      res.auto_seeded = 1'b0;
      if (mt_pos >= STATE_WORDS) begin
        // generate before any seed falls back to the default seed
        if (mt_pos > STATE_WORDS) begin
          mt_seed(DEFAULT_SEED);
          res.auto_seeded = 1'b1;
        end
        mt_twist();
      end
      res.random_word = mt_temper(mt_table[mt_pos]);
      mt_pos++;
      expected_words.push_back(res);
    end
  endfunction

  function automatic void queue_request(logic op, logic [WORD_W-1:0] seed);
    in_req_t req;
    req.operation  = op;
    req.seed_value = seed;
    pending_reqs.push_back(req);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // a request moves when valid is high and the block is not stalling
      if (in_valid && !in_stall) advance_generator(in_req);
      // a stalled request keeps valid and payload untouched
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_req   <= pending_reqs.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // a zero gap runs two bursts together into a longer busy stretch
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: stall pattern that changes mode every so often, plus one
  // long hold-off so the request buffer fills and the block stalls its input
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          default:      out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result: expected none, got word %h auto_seeded %b",
                 $time, out_res.random_word, out_res.auto_seeded);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_res.random_word !== want.random_word) begin
          $display("%0t: random_word mismatch: expected %h, got %h",
                   $time, want.random_word, out_res.random_word);
          errors++;
        end
        if (out_res.auto_seeded !== want.auto_seeded) begin
          $display("%0t: auto_seeded mismatch: expected %b, got %b",
                   $time, want.auto_seeded, out_res.auto_seeded);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too many cycles with no request and no result moving
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_mersenne_twister_prng: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int added;
    int n;

    // generate before any seed: self-seeds with 5489, twists, flags the word;
    // the ignored seed field carries all ones and then all zeros
    queue_request(OP_GENERATE, 32'hFFFF_FFFF);
    queue_request(OP_GENERATE, 32'h0000_0000);
    queue_request(OP_GENERATE, $urandom);
    // seed extremes, each followed by generates
    queue_request(OP_SEED, 32'h0000_0000);
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_SEED, 32'hFFFF_FFFF);
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_GENERATE, $urandom);
    // explicit default seed gives the same words as the self-seed, no flag
    queue_request(OP_SEED, DEFAULT_SEED);
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_GENERATE, $urandom);
    // back-to-back seeds, only the second one counts
    queue_request(OP_SEED, 32'h0000_0001);
    queue_request(OP_SEED, 32'h8000_0000);
    queue_request(OP_GENERATE, $urandom);
    // reseed in the middle of a stream sends the position back to a twist
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_SEED, 32'h5555_AAAA);
    queue_request(OP_GENERATE, $urandom);
    queue_request(OP_GENERATE, $urandom);

    // random part: mostly seed-then-generate runs with random content, some
    // plain generate runs, repeated seeds and a loose mix
    added = 0;
    while (added < RANDOM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          queue_request(OP_SEED, $urandom);
          n = $urandom_range(1, 30);
          repeat (n) queue_request(OP_GENERATE, $urandom);
          added += n + 1;
        end
        6, 7: begin
          n = $urandom_range(1, 20);
          repeat (n) queue_request(OP_GENERATE, $urandom);
          added += n;
        end
        8: begin
          queue_request(OP_SEED, $urandom);
          queue_request(OP_SEED, $urandom);
          n = $urandom_range(1, 3);
          repeat (n) queue_request(OP_GENERATE, $urandom);
          added += n + 2;
        end
        default: begin
          n = $urandom_range(1, 8);
          repeat (n)
            queue_request(($urandom_range(0, 5) == 0) ? OP_SEED : OP_GENERATE, $urandom);
          added += n;
        end
      endcase
    end

    // synchronous reset, held low from the start and then released
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // everything offered, accepted and answered
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0);

    // a trailing seed keeps the block busy for a full table fill; let it
    // finish so any stray result still shows up
    repeat (STATE_WORDS + 64) @(negedge clk);

    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_mersenne_twister_prng: done, clean");
    end else begin
      $display("tb_mersenne_twister_prng: done, errors");
    end
    $finish;
  end

endmodule
